FILE: design/pn3_pkg.sv
package pn3_pkg;

  // Item kinds on the input channel.
  typedef enum logic {
    KindLoad = 1'b0,
    KindEval = 1'b1
  } kind_e;

  // Permutation table geometry.
  localparam int PermDepth = 256;
  localparam int PermWidth = 8;

  // Result format: signed, 16 fraction bits, saturated to +/- 2.0.
  localparam int OutFrac  = 16;
  localparam int OutWidth = 19;
  localparam int OutMax   = 131072;

endpackage

FILE: design/pn3_ram.sv
module pn3_ram #(
  parameter int Width = 8,
  parameter int Depth = 256,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port and two registered read ports.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

FILE: design/perlin_noise_3d_eval_top.sv
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i/in_ready_o  | kind_i, table_index_i, table_value_i,
//         |           |                        | x_coord_i, y_coord_i, z_coord_i
// out     | output    | out_valid_o/out_ready_i| noise_value_o
//
// One transaction is taken in every cycle while the output is not stalled; an
// evaluation passes through seven pipeline stages plus the output register.
// The depth is set by the four chained multiplies of the fade curve and the
// three blend levels, each one multiply per stage.
// Reset clears the valid bits and load markers only; the seven permutation table copies are
// undefined until loaded. A stalled output freezes the whole pipeline, and
// in_ready_o is low only while a result waits and out_ready_i is low.
module perlin_noise_3d_eval_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  table_index_i,
  input  logic [7:0]  table_value_i,
  input  logic signed [31:0] x_coord_i,
  input  logic signed [31:0] y_coord_i,
  input  logic signed [31:0] z_coord_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [pn3_pkg::OutWidth-1:0] noise_value_o
);

  // Fade intermediates, blend values and output scaling widths.
  localparam int W  = FRAC_BITS + 6;
  localparam int DW = FRAC_BITS + 4;
  localparam int SW = FRAC_BITS + 12;
  localparam int ShR = (FRAC_BITS >= pn3_pkg::OutFrac) ? FRAC_BITS - pn3_pkg::OutFrac : 0;
  localparam int ShL = (FRAC_BITS < pn3_pkg::OutFrac) ? pn3_pkg::OutFrac - FRAC_BITS : 0;
  localparam logic signed [W-1:0]  OneW  = W'(1) << FRAC_BITS;
  localparam logic signed [DW-1:0] OneD  = DW'(1) << FRAC_BITS;
  localparam logic signed [SW-1:0] RndO  = (ShR > 0) ? (SW'(1) << (ShR - 1)) : SW'(0);
  localparam logic signed [SW-1:0] SatMx = SW'(pn3_pkg::OutMax);

  // Product of two fixed-point values, rounded half up.
  function automatic logic signed [W-1:0] qmul_f(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
    logic signed [2*W-1:0] p;
    p = a * b;
    p = p + ((2*W)'(1) << (FRAC_BITS - 1));
    return W'(p >>> FRAC_BITS);
  endfunction

  // Linear blend a + t * (b - a).
  function automatic logic signed [DW-1:0] blend_f(input logic signed [W-1:0] t,
                                                   input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
    logic signed [DW:0]      d;
    logic signed [W+DW:0]    p;
    d = (DW+1)'(b) - (DW+1)'(a);
    p = d * t;
    p = p + ((W+DW+1)'(1) << (FRAC_BITS - 1));
    return a + DW'(p >>> FRAC_BITS);
  endfunction

  // Gradient dot product selected by the low four hash bits.
  function automatic logic signed [DW-1:0] dot_f(input logic [3:0] h,
                                                 input logic signed [DW-1:0] x,
                                                 input logic signed [DW-1:0] y,
                                                 input logic signed [DW-1:0] z);
    logic signed [DW-1:0] u;
    logic signed [DW-1:0] v;
    u = (h < 4'd8) ? x : y;
    v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
    if (h[0]) begin
      u = -u;
    end
    if (h[1]) begin
      v = -v;
    end
    return u + v;
  endfunction

  logic adv;
  logic in_fire;
  logic in_eval;
  logic in_load;

  // The whole pipeline moves unless a finished result is held.
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;
  assign in_fire    = in_valid_i && in_ready_o;
  assign in_eval    = in_fire && (pn3_pkg::kind_e'(kind_i) == pn3_pkg::KindEval);
  assign in_load    = in_fire && (pn3_pkg::kind_e'(kind_i) == pn3_pkg::KindLoad);

  // Stage 0: split the coordinates and start the fade curve.
  logic [31:0]          crd [3];
  logic [7:0]           cell0 [3];
  logic [FRAC_BITS-1:0] frac0 [3];
  logic signed [W-1:0]  fm0 [3];

  assign crd[0] = x_coord_i;
  assign crd[1] = y_coord_i;
  assign crd[2] = z_coord_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cell0[i] = crd[i][FRAC_BITS+7:FRAC_BITS];
      frac0[i] = crd[i][FRAC_BITS-1:0];
      fm0[i]   = W'(qmul_f(W'(frac0[i]), W'(6 * W'(frac0[i]) - 15 * OneW)) + 10 * OneW);
    end
  end

  // Pipeline registers.
  logic                 v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  logic                 ld1_q, ld2_q;
  logic [7:0]           ldi1_q, ldv1_q, ldi2_q, ldv2_q;
  logic [FRAC_BITS-1:0] t1_q [3];
  logic [FRAC_BITS-1:0] t2_q [3];
  logic [FRAC_BITS-1:0] t3_q [3];
  logic signed [W-1:0]  fm1_q [3];
  logic signed [W-1:0]  fm2_q [3];
  logic signed [W-1:0]  fm3_q [3];
  logic signed [W-1:0]  fade4_q [3];
  logic signed [W-1:0]  fv5_q, fw5_q, fw6_q;
  logic [7:0]           cy1_q, cz1_q, cz2_q;
  logic signed [DW-1:0] dot4_q [8];
  logic signed [DW-1:0] bx5_q [4];
  logic signed [DW-1:0] by6_q [2];
  logic signed [DW-1:0] bz7_q;
  logic                 out_valid_q;
  logic signed [pn3_pkg::OutWidth-1:0] noise_q;

  // First hash level: one table copy, read at cx and cx + 1.
  logic [7:0] p1_lo, p1_hi;

  pn3_ram #(.Width(pn3_pkg::PermWidth), .Depth(pn3_pkg::PermDepth)) u_ram_l1 (
    .clk_i     (clk_i),
    .we_i      (in_load),
    .waddr_i   (table_index_i),
    .wdata_i   (table_value_i),
    .re_i      (adv),
    .raddr_a_i (cell0[0]),
    .raddr_b_i (cell0[0] + 8'd1),
    .rdata_a_o (p1_lo),
    .rdata_b_o (p1_hi)
  );

  // Second hash level: copies for a and b, each read at the entry and the next.
  logic [7:0] l2_addr [2];
  logic [7:0] p2_lo [2];
  logic [7:0] p2_hi [2];

  assign l2_addr[0] = p1_lo + cy1_q;
  assign l2_addr[1] = p1_hi + cy1_q;

  for (genvar g = 0; g < 2; g++) begin : gen_l2
    pn3_ram #(.Width(pn3_pkg::PermWidth), .Depth(pn3_pkg::PermDepth)) u_ram (
      .clk_i     (clk_i),
      .we_i      (ld1_q && adv),
      .waddr_i   (ldi1_q),
      .wdata_i   (ldv1_q),
      .re_i      (adv),
      .raddr_a_i (l2_addr[g]),
      .raddr_b_i (l2_addr[g] + 8'd1),
      .rdata_a_o (p2_lo[g]),
      .rdata_b_o (p2_hi[g])
    );
  end

  // Third level: copies for aa, ab, ba and bb give the eight corner hashes.
  logic [7:0] l3_addr [4];
  logic [7:0] h_lo [4];
  logic [7:0] h_hi [4];

  assign l3_addr[0] = p2_lo[0] + cz2_q;
  assign l3_addr[1] = p2_hi[0] + cz2_q;
  assign l3_addr[2] = p2_lo[1] + cz2_q;
  assign l3_addr[3] = p2_hi[1] + cz2_q;

  for (genvar g = 0; g < 4; g++) begin : gen_l3
    pn3_ram #(.Width(pn3_pkg::PermWidth), .Depth(pn3_pkg::PermDepth)) u_ram (
      .clk_i     (clk_i),
      .we_i      (ld2_q && adv),
      .waddr_i   (ldi2_q),
      .wdata_i   (ldv2_q),
      .re_i      (adv),
      .raddr_a_i (l3_addr[g]),
      .raddr_b_i (l3_addr[g] + 8'd1),
      .rdata_a_o (h_lo[g]),
      .rdata_b_o (h_hi[g])
    );
  end

  // Stage 3: corner offsets and the eight gradient dot products.
  logic signed [DW-1:0] fx3, fy3, fz3, gx3, gy3, gz3;
  logic signed [DW-1:0] dot3 [8];

  always_comb begin
    fx3 = DW'(t3_q[0]);
    fy3 = DW'(t3_q[1]);
    fz3 = DW'(t3_q[2]);
    gx3 = fx3 - OneD;
    gy3 = fy3 - OneD;
    gz3 = fz3 - OneD;
    dot3[0] = dot_f(h_lo[0][3:0], fx3, fy3, fz3);
    dot3[1] = dot_f(h_lo[2][3:0], gx3, fy3, fz3);
    dot3[2] = dot_f(h_lo[1][3:0], fx3, gy3, fz3);
    dot3[3] = dot_f(h_lo[3][3:0], gx3, gy3, fz3);
    dot3[4] = dot_f(h_hi[0][3:0], fx3, fy3, gz3);
    dot3[5] = dot_f(h_hi[2][3:0], gx3, fy3, gz3);
    dot3[6] = dot_f(h_hi[1][3:0], fx3, gy3, gz3);
    dot3[7] = dot_f(h_hi[3][3:0], gx3, gy3, gz3);
  end

  // Stage 7: move to 16 fraction bits and saturate.
  logic signed [SW-1:0] rs7;
  logic signed [pn3_pkg::OutWidth-1:0] noise_d;

  always_comb begin
    rs7 = ((SW'(bz7_q) + RndO) >>> ShR) <<< ShL;
    if (rs7 > SatMx) begin
      rs7 = SatMx;
    end else if (rs7 < -SatMx) begin
      rs7 = -SatMx;
    end
    noise_d = rs7[pn3_pkg::OutWidth-1:0];
  end

  // Valid bits and load markers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      v7_q        <= 1'b0;
      ld1_q       <= 1'b0;
      ld2_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= in_eval;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      v6_q        <= v5_q;
      v7_q        <= v6_q;
      out_valid_q <= v7_q;
      ld1_q       <= in_load;
      ld2_q       <= ld1_q;
    end
  end

  // Payload registers, frozen during a stall.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ldi1_q <= table_index_i;
      ldv1_q <= table_value_i;
      ldi2_q <= ldi1_q;
      ldv2_q <= ldv1_q;
      cy1_q  <= cell0[1];
      cz1_q  <= cell0[2];
      cz2_q  <= cz1_q;
      for (int i = 0; i < 3; i++) begin
        t1_q[i]    <= frac0[i];
        t2_q[i]    <= t1_q[i];
        t3_q[i]    <= t2_q[i];
        fm1_q[i]   <= fm0[i];
        fm2_q[i]   <= qmul_f(W'(t1_q[i]), fm1_q[i]);
        fm3_q[i]   <= qmul_f(W'(t2_q[i]), fm2_q[i]);
        fade4_q[i] <= qmul_f(W'(t3_q[i]), fm3_q[i]);
      end
      for (int k = 0; k < 8; k++) begin
        dot4_q[k] <= dot3[k];
      end
      for (int k = 0; k < 4; k++) begin
        bx5_q[k] <= blend_f(fade4_q[0], dot4_q[2*k], dot4_q[2*k+1]);
      end
      fv5_q    <= fade4_q[1];
      fw5_q    <= fade4_q[2];
      by6_q[0] <= blend_f(fv5_q, bx5_q[0], bx5_q[1]);
      by6_q[1] <= blend_f(fv5_q, bx5_q[2], bx5_q[3]);
      fw6_q    <= fw5_q;
      bz7_q    <= blend_f(fw6_q, by6_q[0], by6_q[1]);
      noise_q  <= noise_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign noise_value_o = noise_q;

endmodule

FILE: design/pn3_chk.sv
module pn3_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic signed [pn3_pkg::OutWidth-1:0] noise_value_o
);

  localparam logic signed [pn3_pkg::OutWidth-1:0] SatMx = pn3_pkg::OutWidth'(pn3_pkg::OutMax);

  // Results never leave the saturation range.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (noise_value_o <= SatMx && noise_value_o >= -SatMx))
    else $error("noise value out of range");

  // With no result waiting, the input side is always open.
  a_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  // A result holds until it is taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its value.
  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(noise_value_o))
    else $error("result changed while stalled");

endmodule

bind perlin_noise_3d_eval_top pn3_chk u_pn3_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .noise_value_o (noise_value_o)
);
